// ===== rtl/core/ksc_pkg.sv =====
package ksc_pkg;

  localparam int KW_MAX        = 16;
  localparam int KW_IDX_W      = $clog2(KW_MAX);
  localparam int LEN_W         = $clog2(KW_MAX + 1);
  localparam int KEY_REG_BYTES = 16;
  localparam int BUF_MAX       = 4096;
  localparam int POS_W         = $clog2(BUF_MAX + 1);

  localparam int DATA_W   = 8;
  localparam int OFFSET_W = 12;
  localparam int COUNT_W  = 13;
  localparam int TOTAL_W  = 31;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_LEN_W = 5;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2,
    CFG_CASE     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic fold;
  } cell_ctrl_t;

  typedef struct packed {
    result_kind_t         kind;
    logic [OFFSET_W-1:0]  offset;
    logic [COUNT_W-1:0]   count;
    logic [TOTAL_W-1:0]   total;
    logic                 last;
  } result_t;

  // ASCII A-Z to a-z when enabled
  function automatic logic [DATA_W-1:0] fold_byte(input logic [DATA_W-1:0] b,
                                                  input logic en);
    logic [DATA_W-1:0] r;
    r = b;
    if (en && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ksc_in_if.sv =====
interface ksc_in_if import ksc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_in_buffer;
  logic              first_of_search;

  modport source(output valid, data_byte, last_in_buffer, first_of_search, input ready);
  modport sink(input valid, data_byte, last_in_buffer, first_of_search, output ready);
endinterface

// ===== rtl/core/ksc_out_if.sv =====
interface ksc_out_if import ksc_pkg::*;;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [OFFSET_W-1:0] match_offset;
  logic [COUNT_W-1:0]  buffer_match_count;
  logic [TOTAL_W-1:0]  search_match_total;
  logic                last;

  modport source(output valid, result_kind, match_offset, buffer_match_count,
                 search_match_total, last, input ready);
  modport sink(input valid, result_kind, match_offset, buffer_match_count,
               search_match_total, last, output ready);
endinterface

// ===== rtl/core/ksc_cell.sv =====
module ksc_cell import ksc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic              active,
  input  logic [DATA_W-1:0] key_byte,
  input  logic [DATA_W-1:0] shift_in,
  output logic [DATA_W-1:0] byte_q,
  output logic              hit
);

  logic [DATA_W-1:0] byte_r;
  logic [DATA_W-1:0] byte_nxt;

  // compare against the byte this cell holds after the shift
  assign hit = !active ||
               (fold_byte(shift_in, ctrl.fold) == fold_byte(key_byte, ctrl.fold));

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = '0;
    end else if (ctrl.shift) begin
      byte_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_q = byte_r;

endmodule

// ===== rtl/core/ksc_result_fifo.sv =====
module ksc_result_fifo import ksc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  result_t    push0,
  input  result_t    push1,
  input  logic       pop,
  output result_t    head,
  output logic       not_empty,
  output logic       room2
);

  result_t              mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;

  assign head      = mem[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign room2     = (count_r <= RES_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    count_nxt  = count_r + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[RES_PTR_W'(wr_ptr_r + 1'b1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_pair_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (count_r <= RES_CNT_W'(RES_DEPTH - 2)))
    else $error("two results pushed without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != RES_CNT_W'(RES_DEPTH)) |->
      (RES_PTR_W'(wr_ptr_r - rd_ptr_r) == RES_PTR_W'(count_r)))
    else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/core/keyword_scan_counter.sv =====
// Keyword search over a byte stream, one cell per keyword byte.
// A result enters the result queue when its byte is accepted; out_ch presents the queue head.
// Throughput: one byte per cycle while out_ch.ready stays high and each byte yields
// at most one result; a matching buffer end yields two results that drain one per cycle.
// in_ch.ready drops when the four-entry result queue has fewer than two free slots.
// Reset (rst_n low, synchronous) clears window, counters, queue and loads register defaults.
module keyword_scan_counter import ksc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ksc_in_if.sink               in_ch,
  ksc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [2*CFG_W-1:0]   keyword_r;
  logic [CFG_LEN_W-1:0] key_len_r;
  logic                 case_sens_r;

  logic [POS_W-1:0]   pos_r;
  logic [COUNT_W-1:0] bm_r;
  logic [TOTAL_W-1:0] total_r;

  logic [DATA_W-1:0]  key_bytes [KW_MAX];
  logic [DATA_W-1:0]  win       [KW_MAX];
  logic [DATA_W-1:0]  cell_in   [KW_MAX];
  logic [KW_MAX-1:0]  hit;
  logic [LEN_W-1:0]   len_used;

  logic               accept;
  logic               shift_en;
  logic               match;
  logic [POS_W-1:0]   pos_inc;
  logic [COUNT_W-1:0] bm_new;
  logic [TOTAL_W-1:0] total_base;
  logic [TOTAL_W-1:0] total_new;
  cell_ctrl_t         cell_ctrl;

  result_t    res_match, res_sum, push0;
  logic [1:0] push_n;
  result_t    head;
  logic       not_empty;
  logic       room2;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyword_r   <= '0;
      key_len_r   <= CFG_LEN_W'(1);
      case_sens_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KEY_LOW:  keyword_r[CFG_W-1:0]       <= cfg_data;
        CFG_KEY_HIGH: keyword_r[2*CFG_W-1:CFG_W] <= cfg_data;
        CFG_KEY_LEN:  key_len_r                  <= cfg_data[CFG_LEN_W-1:0];
        CFG_CASE:     case_sens_r                <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_len_r == '0) begin
      len_used = LEN_W'(1);
    end else if (key_len_r > CFG_LEN_W'(KW_MAX)) begin
      len_used = LEN_W'(KW_MAX);
    end else begin
      len_used = LEN_W'(key_len_r);
    end
  end

  always_comb begin
    for (int k = 0; k < KW_MAX; k++) begin
      key_bytes[k] = (k < KEY_REG_BYTES) ? keyword_r[8*k +: 8] : '0;
    end
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign shift_en = (pos_r < POS_W'(BUF_MAX));
  assign pos_inc  = pos_r + 1'b1;

  assign cell_ctrl.shift = accept && shift_en;
  assign cell_ctrl.clear = accept && in_ch.last_in_buffer;
  assign cell_ctrl.fold  = !case_sens_r;

  // window cells: cell 0 takes the newest byte, each hands its byte on
  for (genvar j = 0; j < KW_MAX; j++) begin : g_cell
    logic [LEN_W-1:0] key_idx;
    assign key_idx    = len_used - LEN_W'(1) - LEN_W'(j);
    assign cell_in[j] = (j == 0) ? in_ch.data_byte : win[(j == 0) ? 0 : j - 1];

    ksc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .active   (LEN_W'(j) < len_used),
      .key_byte (key_bytes[key_idx[KW_IDX_W-1:0]]),
      .shift_in (cell_in[j]),
      .byte_q   (win[j]),
      .hit      (hit[j])
    );
  end

  assign match = accept && shift_en && (pos_inc >= POS_W'(len_used)) && (&hit);

  always_comb begin
    total_base = in_ch.first_of_search ? '0 : total_r;
    bm_new     = bm_r;
    total_new  = total_base;
    if (match && bm_r != COUNT_SAT) begin
      bm_new = bm_r + 1'b1;
    end
    if (match && total_base != TOTAL_SAT) begin
      total_new = total_base + 1'b1;
    end
  end

  always_comb begin
    res_match.kind   = KIND_MATCH;
    res_match.offset = OFFSET_W'(pos_inc - POS_W'(len_used));
    res_match.count  = bm_new;
    res_match.total  = total_new;
    res_match.last   = !in_ch.last_in_buffer;

    res_sum.kind   = KIND_SUMMARY;
    res_sum.offset = '0;
    res_sum.count  = bm_new;
    res_sum.total  = total_new;
    res_sum.last   = 1'b1;

    push0  = match ? res_match : res_sum;
    push_n = accept ? (2'(match) + 2'(in_ch.last_in_buffer)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      bm_r    <= '0;
      total_r <= '0;
    end else if (accept) begin
      total_r <= total_new;
      if (in_ch.last_in_buffer) begin
        pos_r <= '0;
        bm_r  <= '0;
      end else if (shift_en) begin
        pos_r <= pos_inc;
        bm_r  <= bm_new;
      end
    end
  end

  ksc_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (res_sum),
    .pop       (out_ch.valid && out_ch.ready),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign in_ch.ready               = room2;
  assign out_ch.valid              = not_empty;
  assign out_ch.result_kind        = head.kind;
  assign out_ch.match_offset       = head.offset;
  assign out_ch.buffer_match_count = head.count;
  assign out_ch.search_match_total = head.total;
  assign out_ch.last               = head.last;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(BUF_MAX))
    else $error("buffer position past limit");

  a_matches_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    COUNT_W'(bm_r) <= COUNT_W'(pos_r))
    else $error("more matches than bytes in buffer");

  a_buffer_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_in_buffer) |=> (pos_r == '0 && bm_r == '0))
    else $error("buffer state not cleared at buffer end");

  a_total_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_ch.first_of_search) |=> (total_r >= $past(total_r)))
    else $error("search total decreased");

endmodule
